>>> src/stxf_pkg.sv
package stxf_pkg;

  // Line control bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [3:0] NIB_TEN  = 4'd10;

  // Position within the bytes one request puts on the line
  typedef enum logic [2:0] {
    PH_STX,
    PH_DATA,
    PH_ETX,
    PH_HI,
    PH_LO,
    PH_CR,
    PH_LF
  } phase_t;

  // One accepted request as the sequencer holds it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       need_stx;
    logic [7:0] bcc;
  } item_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic final_step;
  } seq_stat_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < NIB_TEN) begin
      res = CHAR_0 + {4'd0, nib};
    end else begin
      res = CHAR_A + {4'd0, nib - NIB_TEN};
    end
    return res;
  endfunction

endpackage

>>> src/stxf_seq.sv
module stxf_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  stxf_pkg::item_t       load_item,
  input  logic                  advance,
  output logic [7:0]            cur_byte,
  output logic                  cur_done,
  output stxf_pkg::seq_stat_t   stat
);
  import stxf_pkg::*;

  item_t  item_r;
  phase_t phase_r, phase_nxt, phase_step;
  logic   busy_r, busy_nxt;
  logic   final_step;

  // Last byte of the held request
  assign final_step = (phase_r == PH_LF) || ((phase_r == PH_DATA) && !item_r.last);

  assign stat.busy       = busy_r;
  assign stat.final_step = final_step;

  // Step to the following byte
  always_comb begin
    case (phase_r)
      PH_STX:  phase_step = PH_DATA;
      PH_DATA: phase_step = PH_ETX;
      PH_ETX:  phase_step = PH_HI;
      PH_HI:   phase_step = PH_LO;
      PH_LO:   phase_step = PH_CR;
      PH_CR:   phase_step = PH_LF;
      default: phase_step = PH_LF;
    endcase
  end

  // Load a new request, advance or drop the finished one
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = load_item.need_stx ? PH_STX : PH_DATA;
    end else if (advance && final_step) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      phase_nxt = phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_STX;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  // Select the byte for the current position
  always_comb begin
    cur_done = 1'b0;
    case (phase_r)
      PH_STX:  cur_byte = BYTE_STX;
      PH_DATA: cur_byte = item_r.data;
      PH_ETX:  cur_byte = BYTE_ETX;
      PH_HI:   cur_byte = hex_digit(item_r.bcc[7:4]);
      PH_LO:   cur_byte = hex_digit(item_r.bcc[3:0]);
      PH_CR:   cur_byte = BYTE_CR;
      PH_LF: begin
        cur_byte = BYTE_LF;
        cur_done = 1'b1;
      end
      default: cur_byte = BYTE_LF;
    endcase
  end

endmodule

>>> src/stx_etx_bcc_frame_builder_top.sv
// The first line byte of a request goes from the sequencer through the output register to the outputs.
// Throughput: one byte per cycle on the line while out_stall is low; a request inside an open
// frame that is not the last is one line byte; STX adds one, a last byte adds five trailer bytes.
// The output register lets a new request in while a line byte still waits.
// Reset (rst_n low, synchronous) closes any open frame, clears the check byte and
// empties the sequencer and the output register.
module stx_etx_bcc_frame_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_frame_done
);
  import stxf_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic [7:0] chk_sum;
  logic       accept, out_load, advance;
  item_t      new_item;
  seq_stat_t  seq_stat;
  logic [7:0] cur_byte;
  logic       cur_done;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_done_r;

  // Handshake
  assign out_load = !out_valid_r || !out_stall;
  assign advance  = seq_stat.busy && out_load;
  assign in_stall = seq_stat.busy && !(out_load && seq_stat.final_step);
  assign accept   = in_valid && !in_stall;

  // Fold the payload byte into the running check
  assign chk_sum = (open_r ? chk_r : 8'h00) ^ in_payload_byte;

  always_comb begin
    new_item.data     = in_payload_byte;
    new_item.last     = in_is_last;
    new_item.need_stx = !open_r;
    new_item.bcc      = chk_sum ^ BYTE_ETX;
  end

  // Track the open frame and its check byte
  always_comb begin
    open_nxt = open_r;
    chk_nxt  = chk_r;
    if (accept) begin
      open_nxt = !in_is_last;
      chk_nxt  = in_is_last ? 8'h00 : chk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      chk_r  <= 8'h00;
    end else begin
      open_r <= open_nxt;
      chk_r  <= chk_nxt;
    end
  end

  stxf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_item (new_item),
    .advance   (advance),
    .cur_byte  (cur_byte),
    .cur_done  (cur_done),
    .stat      (seq_stat)
  );

  // Output register
  assign out_valid_nxt = out_load ? advance : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= cur_byte;
      out_done_r <= cur_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_byte  = out_byte_r;
  assign out_frame_done = out_done_r;

endmodule

>>> src/stxf_checker.sv
module stxf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_payload_byte,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_line_byte,
  input logic       out_frame_done
);
  import stxf_pkg::*;

  // The line is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_payload_byte)
                                && $stable(in_is_last)))
    else $error("stalled request changed");

  // A frame closes only on LF
  a_done_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_line_byte == BYTE_LF))
    else $error("frame_done on a byte other than LF");

  // A stalled line byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_line_byte)
                                  && $stable(out_frame_done)))
    else $error("stalled line byte changed");

  // LF is always preceded by CR on the line
  a_cr_before_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_frame_done) |->
      $past(out_valid && !out_stall && out_line_byte == BYTE_CR, 1) ||
      $past(out_valid && out_stall, 1))
    else $error("LF without a preceding CR");

endmodule

bind stx_etx_bcc_frame_builder_top stxf_checker u_stxf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_payload_byte(in_payload_byte),
  .in_is_last     (in_is_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_line_byte  (out_line_byte),
  .out_frame_done (out_frame_done)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import stxf_pkg::*;

  // One request as the stimulus holds it; typed rows carry their line bytes,
  // first byte in the top eight bits
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [2:0]  cnt;
    logic [55:0] bytes;
  } req_row_t;

  // One line byte as it should appear on the result channel
  typedef struct packed {
    logic [7:0] line;
    logic       done;
  } line_rec_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_ITEMS  = 410;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_payload_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_line_byte;
  logic       out_frame_done;

  // Framer shadow state
  logic       frame_open = 1'b0;
  logic [7:0] bcc_acc = 8'h00;

  line_rec_t   frame_bytes_q [$];
  line_rec_t   line_q [$];
  req_row_t    req_notes_q [$];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 4;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  stx_etx_bcc_frame_builder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_payload_byte(in_payload_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_byte  (out_line_byte),
    .out_frame_done (out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    if (nib < NIB_TEN) begin
      return CHAR_0 + {4'd0, nib};
    end
    return CHAR_A + {4'd0, nib} - {4'd0, NIB_TEN};
  endfunction

  // Advance the framer shadow by one request and collect its line bytes
  function automatic void predict_line_bytes(input logic [7:0] d, input logic l);
    logic [7:0] chk;
    frame_bytes_q.delete();
    if (!frame_open) begin
      frame_bytes_q.push_back('{BYTE_STX, 1'b0});
      frame_open = 1'b1;
      bcc_acc = 8'h00;
    end
    frame_bytes_q.push_back('{d, 1'b0});
    bcc_acc = bcc_acc ^ d;
    if (l) begin
      chk = bcc_acc ^ BYTE_ETX;
      frame_bytes_q.push_back('{BYTE_ETX, 1'b0});
      frame_bytes_q.push_back('{ascii_nibble(chk[7:4]), 1'b0});
      frame_bytes_q.push_back('{ascii_nibble(chk[3:0]), 1'b0});
      frame_bytes_q.push_back('{BYTE_CR, 1'b0});
      frame_bytes_q.push_back('{BYTE_LF, 1'b1});
      frame_open = 1'b0;
      bcc_acc = 8'h00;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [8:0] want,
                                 input logic [8:0] got);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch: %s expected %h got %h at %0t", what, want, got, $time);
    end
    err_count++;
  endtask

  // Predict on each accepted request, check each accepted line byte
  always @(posedge clk) begin : mon
    req_row_t  row;
    line_rec_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        row = req_notes_q.pop_front();
        predict_line_bytes(in_payload_byte, in_is_last);
        if (row.typed) begin
          for (int i = 0; i < row.cnt; i++) begin
            line_q.push_back('{row.bytes[55 - 8*i -: 8], row.last && (i == row.cnt - 1)});
          end
        end else begin
          foreach (frame_bytes_q[i]) line_q.push_back(frame_bytes_q[i]);
        end
      end
      if (out_valid && !out_stall) begin
        if (line_q.size() == 0) begin
          report_mismatch("unexpected line byte", 9'h000, {out_line_byte, out_frame_done});
        end else begin
          want = line_q.pop_front();
          if (out_line_byte !== want.line) begin
            report_mismatch("line_byte", {1'b0, want.line}, {1'b0, out_line_byte});
          end
          if (out_frame_done !== want.done) begin
            report_mismatch("frame_done", {8'h00, want.done}, {8'h00, out_frame_done});
          end
        end
      end
    end
  end

  // Receiver stall pattern: switch to a random mode whenever the mode countdown runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // Watchdog: end the run when no request and no line byte moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one request and hold it until it is taken
  task automatic send_req(input req_row_t row);
    in_valid <= 1'b1;
    in_payload_byte <= row.data;
    in_is_last <= row.last;
    req_notes_q.push_back(row);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Close a burst now and then with a random gap
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every predicted line byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    req_row_t dir_rows [$];
    req_row_t row;
    int       rand_sent;
    int       len;

    // Directed rows: single-byte frames with known checks, then longer messages
    dir_rows.push_back('{8'h00, 1'b1, 1'b1, 3'd7, 56'h02_00_03_30_33_0D_0A});
    dir_rows.push_back('{8'hFF, 1'b1, 1'b1, 3'd7, 56'h02_FF_03_46_43_0D_0A});
    dir_rows.push_back('{8'h03, 1'b1, 1'b1, 3'd7, 56'h02_03_03_30_30_0D_0A});
    dir_rows.push_back('{8'h99, 1'b1, 1'b1, 3'd7, 56'h02_99_03_39_41_0D_0A});
    dir_rows.push_back('{8'hAA, 1'b1, 1'b1, 3'd7, 56'h02_AA_03_41_39_0D_0A});
    dir_rows.push_back('{8'h0C, 1'b1, 1'b1, 3'd7, 56'h02_0C_03_30_46_0D_0A});
    dir_rows.push_back('{8'hF3, 1'b1, 1'b1, 3'd7, 56'h02_F3_03_46_30_0D_0A});
    dir_rows.push_back('{8'h12, 1'b0, 1'b1, 3'd2, 56'h02_12_00_00_00_00_00});
    dir_rows.push_back('{8'h34, 1'b1, 1'b1, 3'd6, 56'h34_03_32_35_0D_0A_00});
    dir_rows.push_back('{8'hFF, 1'b0, 1'b1, 3'd2, 56'h02_FF_00_00_00_00_00});
    dir_rows.push_back('{8'h00, 1'b0, 1'b1, 3'd1, 56'h00_00_00_00_00_00_00});
    dir_rows.push_back('{8'h80, 1'b0, 1'b0, 3'd0, 56'h0});
    dir_rows.push_back('{8'h7F, 1'b0, 1'b0, 3'd0, 56'h0});
    dir_rows.push_back('{8'h55, 1'b0, 1'b0, 3'd0, 56'h0});
    dir_rows.push_back('{8'hAA, 1'b1, 1'b0, 3'd0, 56'h0});
    // Walking one across a message, last flag on the final byte
    for (int b = 0; b < 8; b++) begin
      dir_rows.push_back('{8'h01 << b, b == 7, 1'b0, 3'd0, 56'h0});
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i]);
      if (i == dir_rows.size() - 1) begin
        drain();
      end else begin
        pace();
      end
    end

    // Random messages: mostly short, some medium, a few long
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(21, 48);
        1, 2, 3, 4, 5: len = $urandom_range(7, 20);
        default: len = $urandom_range(1, 6);
      endcase
      for (int k = 0; k < len; k++) begin
        row = '{rand_byte(), k == len - 1, 1'b0, 3'd0, 56'h0};
        send_req(row);
        rand_sent++;
        if (k == len - 1 && $urandom_range(0, 14) == 0) begin
          drain();
        end else begin
          pace();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/stxf_pkg.sv
src/stxf_seq.sv
src/stx_etx_bcc_frame_builder_top.sv
src/stxf_checker.sv
test/testbench.sv
